/* rtl/core/crf_pkg.sv */
// Package for the clipped rectangle fill command generator.
// Panel geometry, panel command codes, run item indexes and the queued descriptor type.
// Depends on nothing; every module in rtl/core imports it.
package crf_pkg;

  localparam int PANEL_WIDTH  = 320;
  localparam int PANEL_HEIGHT = 480;
  localparam int DIM_MAX      = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;

  localparam int COORD_W = 16;
  localparam int SPAN_W  = $clog2(DIM_MAX + 1);
  localparam int PROD_W  = 2 * SPAN_W;
  localparam int COUNT_W = 18;
  localparam int SAT_W   = (PROD_W > COUNT_W) ? PROD_W : COUNT_W;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET    = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;

  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] ITEM_CASET    = 4'd0;
  localparam logic [IDX_W-1:0] ITEM_X0_HI    = 4'd1;
  localparam logic [IDX_W-1:0] ITEM_X0_LO    = 4'd2;
  localparam logic [IDX_W-1:0] ITEM_X1_HI    = 4'd3;
  localparam logic [IDX_W-1:0] ITEM_X1_LO    = 4'd4;
  localparam logic [IDX_W-1:0] ITEM_PASET    = 4'd5;
  localparam logic [IDX_W-1:0] ITEM_Y0_HI    = 4'd6;
  localparam logic [IDX_W-1:0] ITEM_Y0_LO    = 4'd7;
  localparam logic [IDX_W-1:0] ITEM_Y1_HI    = 4'd8;
  localparam logic [IDX_W-1:0] ITEM_Y1_LO    = 4'd9;
  localparam logic [IDX_W-1:0] ITEM_RAMWR    = 4'd10;
  localparam logic [IDX_W-1:0] ITEM_FILL     = 4'd11;

  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic [15:0]        color;
    logic [COUNT_W-1:0] count;
  } crf_desc_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [QCNT_W-1:0] count;
  } crf_qstat_t;

endpackage

/* rtl/core/crf_front.sv */
// Front end: accepts rectangle requests, clips them to the rotated display,
// computes the pixel count and pushes one descriptor per visible request.
// Depends on crf_pkg.
module crf_front import crf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  rect_x,
  input  logic signed [15:0]  rect_y,
  input  logic signed [15:0]  rect_width,
  input  logic signed [15:0]  rect_height,
  input  logic [15:0]         fill_color_in,
  input  logic                rotation_write,
  input  logic [1:0]          rotation_data,
  input  logic [QCNT_W-1:0]   q_count,
  output logic                push,
  output crf_desc_t           push_desc
);

  logic [1:0] rotation;

  logic signed [16:0] xs, ys, ws, hs, dw, dh, x2, y2;
  logic signed [16:0] cx0, cy0, cx1, cy1;
  logic               visible;
  logic               accept;

  logic               s1_valid;
  logic [COORD_W-1:0] s1_x0, s1_x1, s1_y0, s1_y1;
  logic [15:0]        s1_color;

  logic               s2_valid;
  crf_desc_t          s2_desc;

  logic [COORD_W-1:0] cw_full, ch_full;
  logic [SPAN_W-1:0]  cw, ch;
  logic [PROD_W-1:0]  prod;
  logic [SAT_W-1:0]   prod_ext;
  logic [COUNT_W-1:0] count_sat;
  logic [QCNT_W:0]    inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= 2'd0;
    end else if (rotation_write) begin
      rotation <= rotation_data;
    end
  end

  // credits cover every request between accept and queue entry
  assign inflight = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid) + (QCNT_W+1)'(s2_valid);
  assign busy     = inflight >= (QCNT_W+1)'(QDEPTH);
  assign accept   = start && !busy;

  always_comb begin
    xs = {rect_x[15], rect_x};
    ys = {rect_y[15], rect_y};
    ws = {rect_width[15], rect_width};
    hs = {rect_height[15], rect_height};
    dw = rotation[0] ? 17'(PANEL_HEIGHT) : 17'(PANEL_WIDTH);
    dh = rotation[0] ? 17'(PANEL_WIDTH) : 17'(PANEL_HEIGHT);
    x2 = xs + ws - 17'sd1;
    y2 = ys + hs - 17'sd1;
    visible = !(ws <= 17'sd0 || hs <= 17'sd0 || xs >= dw || ys >= dh ||
                x2 < 17'sd0 || y2 < 17'sd0);
    cx0 = (xs < 17'sd0) ? 17'sd0 : xs;
    cy0 = (ys < 17'sd0) ? 17'sd0 : ys;
    cx1 = (x2 >= dw) ? dw - 17'sd1 : x2;
    cy1 = (y2 >= dh) ? dh - 17'sd1 : y2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && visible;
    end
  end

  always_ff @(posedge clk) begin
    s1_x0    <= cx0[COORD_W-1:0];
    s1_x1    <= cx1[COORD_W-1:0];
    s1_y0    <= cy0[COORD_W-1:0];
    s1_y1    <= cy1[COORD_W-1:0];
    s1_color <= fill_color_in;
  end

  always_comb begin
    cw_full  = s1_x1 - s1_x0 + COORD_W'(1);
    ch_full  = s1_y1 - s1_y0 + COORD_W'(1);
    cw       = cw_full[SPAN_W-1:0];
    ch       = ch_full[SPAN_W-1:0];
    prod     = PROD_W'(cw) * PROD_W'(ch);
    prod_ext = SAT_W'(prod);
    count_sat = (prod_ext > SAT_W'(COUNT_MAX)) ? COUNT_MAX : prod_ext[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_desc.x0    <= s1_x0;
    s2_desc.x1    <= s1_x1;
    s2_desc.y0    <= s1_y0;
    s2_desc.y1    <= s1_y1;
    s2_desc.color <= s1_color;
    s2_desc.count <= count_sat;
  end

  assign push      = s2_valid;
  assign push_desc = s2_desc;

endmodule

/* rtl/core/crf_queue.sv */
// Short descriptor queue between the front end and the command sequencer.
// Register array with read and write pointers; depends on crf_pkg.
module crf_queue import crf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  crf_desc_t   push_desc,
  input  logic        pop,
  output crf_desc_t   head,
  output crf_qstat_t  stat
);

  crf_desc_t         entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  assign head       = entries[rd_ptr];
  assign stat.push  = push;
  assign stat.pop   = pop;
  assign stat.count = count;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == QCNT_W'(QDEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue pop while empty");

endmodule

/* rtl/core/crf_seq.sv */
// Back end: pops descriptors and emits the twelve-item command run for each,
// one item per cycle, back to back across descriptors while the queue holds one. Depends on crf_pkg.
module crf_seq import crf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  crf_desc_t          head,
  input  crf_qstat_t         qstat,
  output logic               pop,
  output logic               result_strobe,
  output logic               is_command,
  output logic [7:0]         out_byte,
  output logic               is_fill,
  output logic [15:0]        fill_color,
  output logic [COUNT_W-1:0] fill_count,
  output logic               last
);

  logic             active;
  logic [IDX_W-1:0] idx;
  crf_desc_t        cur;
  logic             at_end;

  assign at_end = active && idx == ITEM_FILL;
  assign pop    = qstat.count != '0 && (!active || idx == ITEM_FILL);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= ITEM_CASET;
    end else if (pop) begin
      active <= 1'b1;
      idx    <= ITEM_CASET;
    end else if (at_end) begin
      active <= 1'b0;
    end else if (active) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_comb begin
    is_command = 1'b0;
    out_byte   = 8'h00;
    is_fill    = 1'b0;
    fill_color = 16'h0000;
    fill_count = '0;
    last       = 1'b0;
    if (active) begin
      unique case (idx)
        ITEM_CASET: begin
          is_command = 1'b1;
          out_byte   = CMD_COLUMN_SET;
        end
        ITEM_X0_HI: out_byte = cur.x0[15:8];
        ITEM_X0_LO: out_byte = cur.x0[7:0];
        ITEM_X1_HI: out_byte = cur.x1[15:8];
        ITEM_X1_LO: out_byte = cur.x1[7:0];
        ITEM_PASET: begin
          is_command = 1'b1;
          out_byte   = CMD_ROW_SET;
        end
        ITEM_Y0_HI: out_byte = cur.y0[15:8];
        ITEM_Y0_LO: out_byte = cur.y0[7:0];
        ITEM_Y1_HI: out_byte = cur.y1[15:8];
        ITEM_Y1_LO: out_byte = cur.y1[7:0];
        ITEM_RAMWR: begin
          is_command = 1'b1;
          out_byte   = CMD_MEM_WRITE;
        end
        ITEM_FILL: begin
          is_fill    = 1'b1;
          fill_color = cur.color;
          fill_count = cur.count;
          last       = 1'b1;
        end
        default: out_byte = 8'h00;
      endcase
    end
  end

  assign result_strobe = active;

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    active && idx != ITEM_FILL |=> active && idx == $past(idx) + IDX_W'(1))
    else $error("command run cut short");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    at_end && !pop |=> !active)
    else $error("sequencer kept running past the fill item");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    active |-> idx <= ITEM_FILL)
    else $error("item index out of range");

endmodule

/* rtl/core/clipped_rect_fill_command_gen.sv */
// Clipped rectangle fill command generator, top level.
// Joins the front end, the descriptor queue and the command sequencer.
// Depends on crf_pkg, crf_front, crf_queue, crf_seq.
//
// Usage:
//   A request (rect_x, rect_y, rect_width, rect_height, fill_color_in) is
//   taken at a clock edge with start high and busy low. A visible request
//   produces twelve results: column-set command and four bytes, row-set
//   command and four bytes, memory-write command, then the fill item with
//   color and pixel count (last high). Requests that are empty or fully off
//   the display produce nothing.
//   Each result is valid for one cycle while result_strobe is high; the
//   receiver cannot stall, so results always leave at one per cycle.
//   The first result follows the accepting edge through the two front
//   stages, the queue and the sequencer's descriptor register. The sequencer
//   emits one item per cycle; runs follow each other without gaps while the
//   queue holds a descriptor. busy rises once four requests are between accept
//   and the sequencer, so short bursts are absorbed.
//   rotation is written with rotation_write/rotation_data; the user must do so while idle, unenforced.
//   Reset (rst, synchronous) empties the pipeline and queue, sets rotation 0.
module clipped_rect_fill_command_gen import crf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] rect_x,
  input  logic signed [15:0] rect_y,
  input  logic signed [15:0] rect_width,
  input  logic signed [15:0] rect_height,
  input  logic [15:0]        fill_color_in,
  input  logic               rotation_write,
  input  logic [1:0]         rotation_data,
  output logic               result_strobe,
  output logic               is_command,
  output logic [7:0]         out_byte,
  output logic               is_fill,
  output logic [15:0]        fill_color,
  output logic [COUNT_W-1:0] fill_count,
  output logic               last
);

  logic       push;
  logic       pop;
  crf_desc_t  push_desc;
  crf_desc_t  head;
  crf_qstat_t qstat;

  crf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .rect_x         (rect_x),
    .rect_y         (rect_y),
    .rect_width     (rect_width),
    .rect_height    (rect_height),
    .fill_color_in  (fill_color_in),
    .rotation_write (rotation_write),
    .rotation_data  (rotation_data),
    .q_count        (qstat.count),
    .push           (push),
    .push_desc      (push_desc)
  );

  crf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  crf_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .result_strobe (result_strobe),
    .is_command    (is_command),
    .out_byte      (out_byte),
    .is_fill       (is_fill),
    .fill_color    (fill_color),
    .fill_count    (fill_count),
    .last          (last)
  );

endmodule
